[hdl/ssk_pkg.sv]
// ----------------------------------------------------------------------------
// ssk_pkg
// Shared types and constants for the shortest span of k ones block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package ssk_pkg;

    localparam int MAX_LEN_DEF = 1024;
    localparam int MAX_K_DEF   = 64;
    localparam int K_W         = 7;
    localparam int LEN_OUT_W   = 11;

    localparam logic [K_W-1:0] K_RESET = K_W'(1);

    typedef struct packed {
        logic flag_bit;
        logic last_item;
    } ssk_in_t;

    typedef struct packed {
        logic [LEN_OUT_W-1:0] shortest_length;
        logic                 window_found;
        logic                 too_long;
    } ssk_out_t;

    // control word handed from the ring front end to the best-length stage
    typedef struct packed {
        logic valid;
        logic cand_en;
        logic k_one;
        logic last;
        logic over;
    } ssk_ctrl_t;

endpackage

`default_nettype wire

[hdl/ssk_ring.sv]
// ----------------------------------------------------------------------------
// ssk_ring
// Single-port-write, single-port-read synchronous memory holding the
// positions of the most recent set flags. Read data is registered.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ssk_ring #(
    parameter int DEPTH  = ssk_pkg::MAX_K_DEF,
    parameter int ADDR_W = 6,
    parameter int DATA_W = 10
) (
    input  wire logic              clk,
    input  wire logic              wr_en,
    input  wire logic [ADDR_W-1:0] wr_addr,
    input  wire logic [DATA_W-1:0] wr_data,
    input  wire logic              rd_en,
    input  wire logic [ADDR_W-1:0] rd_addr,
    output      logic [DATA_W-1:0] rd_data
);

    logic [DATA_W-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

[hdl/ssk_front.sv]
// ----------------------------------------------------------------------------
// ssk_front
// Input stage: counts items, writes set-flag positions into the ring, issues
// the read of the set flag k-1 back and hands a control word onwards.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ssk_front #(
    parameter int MAX_LEN = ssk_pkg::MAX_LEN_DEF,
    parameter int MAX_K   = ssk_pkg::MAX_K_DEF,
    parameter int CNT_W   = $clog2(MAX_LEN + 1),
    parameter int POS_W   = $clog2(MAX_LEN),
    parameter int PTR_W   = (MAX_K > 1) ? $clog2(MAX_K) : 1,
    parameter int HELD_W  = $clog2(MAX_K + 1)
) (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      accept,
    input  wire logic                      adv,
    input  wire ssk_pkg::ssk_in_t          word,
    input  wire logic [ssk_pkg::K_W-1:0]   ones_wanted,
    output      logic                      wr_en,
    output      logic [PTR_W-1:0]          wr_addr,
    output      logic [POS_W-1:0]          wr_data,
    output      logic                      rd_en,
    output      logic [PTR_W-1:0]          rd_addr,
    output      ssk_pkg::ssk_ctrl_t        ctrl,
    output      logic [POS_W-1:0]          pos,
    output      logic [CNT_W-1:0]          count
);

    logic [CNT_W-1:0]   position_reg, position_next;
    logic [PTR_W-1:0]   wp_reg, wp_next;
    logic [HELD_W-1:0]  held_reg, held_next, held_inc;
    logic               overflowed_reg, overflowed_next;
    ssk_pkg::ssk_ctrl_t ctrl_reg, ctrl_next;
    logic [POS_W-1:0]   pos_reg;
    logic [CNT_W-1:0]   count_reg;
    logic               over_now;
    logic               k_valid;
    logic               take_flag;
    logic [31:0]        km1;
    logic [31:0]        back;

    function automatic logic [CNT_W-1:0] position_next_count(
        input logic [CNT_W-1:0] p,
        input logic             ovf
    );
        position_next_count = ovf ? p : p + 1'b1;
    endfunction

    assign over_now  = (position_reg >= CNT_W'(MAX_LEN));
    assign k_valid   = (ones_wanted != '0) && (32'(ones_wanted) <= 32'(MAX_K));
    assign take_flag = word.flag_bit && !over_now;
    assign held_inc  = (32'(held_reg) < 32'(MAX_K)) ? held_reg + 1'b1 : held_reg;
    assign km1       = 32'(ones_wanted) - 32'd1;
    assign back      = (32'(wp_reg) >= km1) ? 32'(wp_reg) - km1
                                             : 32'(wp_reg) + 32'(MAX_K) - km1;

    assign wr_en   = accept && take_flag;
    assign wr_addr = wp_reg;
    assign wr_data = POS_W'(position_reg);
    assign rd_en   = accept;
    assign rd_addr = PTR_W'(back);

    always_comb
    begin
        position_next   = position_reg;
        wp_next         = wp_reg;
        held_next       = held_reg;
        overflowed_next = overflowed_reg;
        ctrl_next       = ctrl_reg;
        if (adv)
        begin
            ctrl_next.valid   = accept;
            ctrl_next.cand_en = take_flag && k_valid &&
                                (32'(held_inc) >= 32'(ones_wanted));
            ctrl_next.k_one   = (ones_wanted == ssk_pkg::K_W'(1));
            ctrl_next.last    = word.last_item;
            ctrl_next.over    = overflowed_reg || over_now;
        end
        if (accept)
        begin
            if (over_now)
            begin
                overflowed_next = 1'b1;
            end
            else
            begin
                position_next = position_reg + 1'b1;
                if (word.flag_bit)
                begin
                    held_next = held_inc;
                    wp_next   = (32'(wp_reg) == 32'(MAX_K - 1)) ? '0 : wp_reg + 1'b1;
                end
            end
            if (word.last_item)
            begin
                position_next   = '0;
                wp_next         = '0;
                held_next       = '0;
                overflowed_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            position_reg   <= '0;
            wp_reg         <= '0;
            held_reg       <= '0;
            overflowed_reg <= 1'b0;
            ctrl_reg       <= '0;
        end
        else
        begin
            position_reg   <= position_next;
            wp_reg         <= wp_next;
            held_reg       <= held_next;
            overflowed_reg <= overflowed_next;
            ctrl_reg       <= ctrl_next;
        end
    end

    // hold item position and count alongside the control word
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            pos_reg   <= POS_W'(position_reg);
            count_reg <= position_next_count(position_reg, over_now);
        end
    end

    assign ctrl  = ctrl_reg;
    assign pos   = pos_reg;
    assign count = count_reg;

    a_pos_bound: assert property (@(posedge clk) disable iff (!rst_n)
        position_reg <= CNT_W'(MAX_LEN))
        else $error("item count beyond limit");

    a_held_bound: assert property (@(posedge clk) disable iff (!rst_n)
        32'(held_reg) <= 32'(MAX_K))
        else $error("held count beyond ring depth");

    a_over_pos: assert property (@(posedge clk) disable iff (!rst_n)
        overflowed_reg |-> (position_reg == CNT_W'(MAX_LEN)))
        else $error("overflow flag set below the length limit");

endmodule

`default_nettype wire

[hdl/ssk_best.sv]
// ----------------------------------------------------------------------------
// ssk_best
// Candidate stage: forms the window length from the ring read, keeps the
// best length of the sequence and drives the result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ssk_best #(
    parameter int CNT_W = 11,
    parameter int POS_W = 10
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire ssk_pkg::ssk_ctrl_t ctrl,
    input  wire logic [POS_W-1:0]   pos,
    input  wire logic [CNT_W-1:0]   count,
    input  wire logic [POS_W-1:0]   rd_data,
    output      logic               adv,
    output      logic               out_valid,
    input  wire logic               out_ready,
    output      ssk_pkg::ssk_out_t  out_data
);

    logic [CNT_W-1:0]  best_reg, best_next, best_eff;
    logic              found_reg, found_next, found_eff;
    logic              out_valid_reg, out_valid_next;
    ssk_pkg::ssk_out_t out_data_reg;
    logic [CNT_W-1:0]  cand;
    logic              take;
    logic [CNT_W:0]    len_none;
    logic              out_free;

    assign out_free  = !out_valid_reg || out_ready;
    assign adv       = out_free || !(ctrl.valid && ctrl.last);
    assign cand      = ctrl.k_one ? CNT_W'(1)
                                  : CNT_W'(pos) - CNT_W'(rd_data) + CNT_W'(1);
    assign take      = ctrl.valid && ctrl.cand_en && (!found_reg || cand < best_reg);
    assign best_eff  = take ? cand : best_reg;
    assign found_eff = found_reg || take;
    assign len_none  = (CNT_W+1)'(count) + 1'b1;

    always_comb
    begin
        best_next      = best_reg;
        found_next     = found_reg;
        out_valid_next = out_valid_reg;
        if (out_free)
        begin
            out_valid_next = ctrl.valid && ctrl.last;
        end
        if (adv)
        begin
            if (ctrl.valid)
            begin
                if (ctrl.last)
                begin
                    best_next  = '1;
                    found_next = 1'b0;
                end
                else
                begin
                    best_next  = best_eff;
                    found_next = found_eff;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            best_reg      <= '1;
            found_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            best_reg      <= best_next;
            found_reg     <= found_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv && ctrl.valid && ctrl.last)
        begin
            out_data_reg.shortest_length <= found_eff
                ? ssk_pkg::LEN_OUT_W'(best_eff) : ssk_pkg::LEN_OUT_W'(len_none);
            out_data_reg.window_found    <= found_eff;
            out_data_reg.too_long        <= ctrl.over;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    a_best_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        found_reg |-> (best_reg != '0))
        else $error("found window with zero length");

    a_stall_best: assert property (@(posedge clk) disable iff (!rst_n)
        !adv |=> ($stable(best_reg) && $stable(found_reg)))
        else $error("best length moved during stall");

    a_stall_read: assert property (@(posedge clk) disable iff (!rst_n)
        !adv |=> $stable(rd_data))
        else $error("ring read data moved during stall");

endmodule

`default_nettype wire

[hdl/shortest_span_k_ones_top.sv]
// ----------------------------------------------------------------------------
// shortest_span_k_ones_top
// Shortest run of consecutive flags holding exactly k set flags.
// ----------------------------------------------------------------------------
// One flag word is taken every cycle unless an unread result waits with
// out_ready low and the last word of a further sequence is already held
// behind it; the result for a sequence is registered from the control word
// of its last word. Each word costs one ring read of the set flag k-1 back,
// a ring write if its flag is set, and one subtract and compare of the
// registered read against the best length, so the rate is set by the single
// read port of the position ring. No clearing pass is needed after reset.
`timescale 1ns / 1ps
`default_nettype none

module shortest_span_k_ones_top #(
    parameter int MAX_LEN = ssk_pkg::MAX_LEN_DEF,
    parameter int MAX_K   = ssk_pkg::MAX_K_DEF
) (
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    in_valid,
    output      logic                    in_ready,
    input  wire ssk_pkg::ssk_in_t        in_data,
    output      logic                    out_valid,
    input  wire logic                    out_ready,
    output      ssk_pkg::ssk_out_t       out_data,
    input  wire logic                    cfg_we,
    input  wire logic [ssk_pkg::K_W-1:0] cfg_data
);

    localparam int CNT_W  = $clog2(MAX_LEN + 1);
    localparam int POS_W  = $clog2(MAX_LEN);
    localparam int PTR_W  = (MAX_K > 1) ? $clog2(MAX_K) : 1;
    localparam int HELD_W = $clog2(MAX_K + 1);

    logic [ssk_pkg::K_W-1:0] ones_wanted_reg;
    logic                    accept;
    logic                    adv;
    logic                    wr_en;
    logic [PTR_W-1:0]        wr_addr;
    logic [POS_W-1:0]        wr_data;
    logic                    rd_en;
    logic [PTR_W-1:0]        rd_addr;
    logic [POS_W-1:0]        rd_data;
    ssk_pkg::ssk_ctrl_t      ctrl;
    logic [POS_W-1:0]        pos;
    logic [CNT_W-1:0]        count;

    assign in_ready = adv;
    assign accept   = in_valid && adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ones_wanted_reg <= ssk_pkg::K_RESET;
        end
        else if (cfg_we)
        begin
            ones_wanted_reg <= cfg_data;
        end
    end

    ssk_front #(
        .MAX_LEN (MAX_LEN),
        .MAX_K   (MAX_K),
        .CNT_W   (CNT_W),
        .POS_W   (POS_W),
        .PTR_W   (PTR_W),
        .HELD_W  (HELD_W)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .accept      (accept),
        .adv         (adv),
        .word        (in_data),
        .ones_wanted (ones_wanted_reg),
        .wr_en       (wr_en),
        .wr_addr     (wr_addr),
        .wr_data     (wr_data),
        .rd_en       (rd_en),
        .rd_addr     (rd_addr),
        .ctrl        (ctrl),
        .pos         (pos),
        .count       (count)
    );

    ssk_ring #(
        .DEPTH  (MAX_K),
        .ADDR_W (PTR_W),
        .DATA_W (POS_W)
    ) u_ring (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    ssk_best #(
        .CNT_W (CNT_W),
        .POS_W (POS_W)
    ) u_best (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctrl      (ctrl),
        .pos       (pos),
        .count     (count),
        .rd_data   (rd_data),
        .adv       (adv),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

endmodule

`default_nettype wire

[verif/shortest_span_k_ones_top_test.sv]
// ----------------------------------------------------------------------------
// shortest_span_k_ones_top_test
// Self-checking bench for the shortest span of k set flags block.
// ----------------------------------------------------------------------------
// Flag words are sent over the input handshake with random gaps and results
// are taken with random back-pressure. A span tracker follows every accepted
// word, predicts the result of each sequence and checks every result word
// field by field, in order. Directed sequences cover the reset value of k,
// k of zero and above the ring depth, and a sequence beyond the length
// limit. Random phases then sweep k across its range, including both ends.
// One phase holds the result side off for a long stretch so the block fills
// and stalls its input. k is only changed once all due results have arrived.
`timescale 1ns / 1ps

module shortest_span_k_ones_top_test;

    localparam int HOLD_CYCLES  = 300;
    localparam int SETTLE       = 8;
    localparam int RAND_WORDS   = 400;
    localparam int RAND_SPANS   = 16;

    class span_tracker;
        logic [ssk_pkg::K_W-1:0] k;
        logic [9:0]              ring [ssk_pkg::MAX_K_DEF];
        int                      seq_pos;
        int                      wr_ptr;
        int                      held;
        int                      best;
        bit                      found;
        bit                      over;
        ssk_pkg::ssk_out_t       spans_due [$];
        int                      errors;

        function new();
            k      = ssk_pkg::K_RESET;
            errors = 0;
            clear_seq();
        endfunction

        function void clear_seq();
            seq_pos = 0;
            wr_ptr  = 0;
            held    = 0;
            best    = 2047;
            found   = 1'b0;
            over    = 1'b0;
        endfunction

        function void take_flag(ssk_pkg::ssk_in_t w);
            int                slot;
            int                back;
            int                cand;
            ssk_pkg::ssk_out_t r;
            if (seq_pos >= ssk_pkg::MAX_LEN_DEF)
            begin
                over = 1'b1;
            end
            else
            begin
                if (w.flag_bit)
                begin
                    slot       = wr_ptr;
                    ring[slot] = 10'(seq_pos);
                    wr_ptr     = (slot + 1) % ssk_pkg::MAX_K_DEF;
                    if (held < ssk_pkg::MAX_K_DEF)
                        held++;
                    if (int'(k) >= 1 && int'(k) <= ssk_pkg::MAX_K_DEF && held >= int'(k))
                    begin
                        back = (slot + ssk_pkg::MAX_K_DEF - (int'(k) - 1))
                               % ssk_pkg::MAX_K_DEF;
                        cand = seq_pos - int'(ring[back]) + 1;
                        if (!found || cand < best)
                        begin
                            best  = cand;
                            found = 1'b1;
                        end
                    end
                end
                seq_pos++;
            end
            if (w.last_item)
            begin
                r.shortest_length = ssk_pkg::LEN_OUT_W'(found ? best : seq_pos + 1);
                r.window_found    = found;
                r.too_long        = over;
                spans_due.push_back(r);
                clear_seq();
            end
        endfunction

        function void check_span(ssk_pkg::ssk_out_t got);
            ssk_pkg::ssk_out_t want;
            if (spans_due.size() == 0)
            begin
                $error("result word with no span due: %p", got);
                errors++;
                return;
            end
            want = spans_due.pop_front();
            if (got.shortest_length !== want.shortest_length)
            begin
                $error("shortest_length: expected %0d, got %0d",
                       want.shortest_length, got.shortest_length);
                errors++;
            end
            if (got.window_found !== want.window_found)
            begin
                $error("window_found: expected %0b, got %0b",
                       want.window_found, got.window_found);
                errors++;
            end
            if (got.too_long !== want.too_long)
            begin
                $error("too_long: expected %0b, got %0b", want.too_long, got.too_long);
                errors++;
            end
        endfunction

        function int pending();
            return spans_due.size();
        endfunction
    endclass

    logic                    clk       = 1'b0;
    logic                    rst_n     = 1'b0;
    logic                    in_valid  = 1'b0;
    logic                    in_ready;
    ssk_pkg::ssk_in_t        in_data   = '0;
    logic                    out_valid;
    logic                    out_ready = 1'b0;
    ssk_pkg::ssk_out_t       out_data;
    logic                    cfg_we    = 1'b0;
    logic [ssk_pkg::K_W-1:0] cfg_data  = '0;

    span_tracker    tracker   = new();
    bit             calm      = 1'b0;
    bit             hold_req  = 1'b0;
    bit             offering  = 1'b0;
    int             next_gap  = 0;

    shortest_span_k_ones_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_we    (cfg_we),
        .cfg_data  (cfg_data)
    );

    always #5 clk = ~clk;

    function automatic int pick_gap();
        int r;
        if (calm)
            return 0;
        r = $urandom_range(99);
        if (r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    task automatic stop_offer();
        if (offering)
        begin
            in_valid <= 1'b0;
            offering = 1'b0;
        end
    endtask

    task automatic send_flag(bit f, bit last);
        ssk_pkg::ssk_in_t w;
        w.flag_bit  = f;
        w.last_item = last;
        if (next_gap > 0)
        begin
            stop_offer();
            repeat (next_gap) @(posedge clk);
        end
        in_data  <= w;
        in_valid <= 1'b1;
        offering = 1'b1;
        do
            @(posedge clk);
        while (!in_ready);
        tracker.take_flag(w);
        next_gap = pick_gap();
        if (next_gap > 0)
            stop_offer();
    endtask

    task automatic send_pattern(string s);
        for (int i = 0; i < s.len(); i++)
            send_flag(s[i] == "1", i == s.len() - 1);
    endtask

    task automatic send_seq(int len, int pct);
        for (int i = 0; i < len; i++)
            send_flag($urandom_range(99) < pct, i == len - 1);
    endtask

    task automatic drain();
        stop_offer();
        while (tracker.pending() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic set_k(logic [ssk_pkg::K_W-1:0] k);
        drain();
        cfg_data <= k;
        cfg_we   <= 1'b1;
        @(posedge clk);
        cfg_we   <= 1'b0;
        tracker.k = k;
    endtask

    // result side: random stalls, plus one long hold on request
    initial
    begin
        int stall_left;
        stall_left = 0;
        forever
        begin
            @(posedge clk);
            if (out_valid && out_ready)
                tracker.check_span(out_data);
            if (hold_req)
            begin
                hold_req = 1'b0;
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            else if (stall_left > 0)
            begin
                stall_left--;
                out_ready <= 1'b0;
            end
            else
            begin
                out_ready <= 1'b1;
                if (!calm && $urandom_range(3) == 0)
                    stall_left = pick_gap();
            end
        end
    end

    initial
    begin
        #(64'd20_000_000);
        $display("shortest_span_k_ones_top regression: fail");
        $finish;
    end

    initial
    begin
        logic [ssk_pkg::K_W-1:0] k;
        int                      rand_words;
        int                      spans_sent;
        int                      phase;
        int                      hi;
        int                      len;
        rand_words = 0;
        spans_sent = 0;
        phase      = 0;

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // k at its reset value
        send_pattern("1");
        send_pattern("0");
        set_k(1);
        send_pattern("01");
        set_k(2);
        send_pattern("10011");
        send_pattern("101");
        set_k(3);
        send_pattern("1101");
        set_k(0);
        send_pattern("11");
        set_k(127);
        send_pattern("111");

        // length limit: past it
        set_k(5);
        send_seq(ssk_pkg::MAX_LEN_DEF + 3, 20);

        // hold the result side while short sequences keep coming
        set_k(1);
        calm     = 1'b1;
        hold_req = 1'b1;
        repeat (40)
            send_seq($urandom_range(1, 4), 50);
        drain();
        calm = 1'b0;

        while (rand_words < RAND_WORDS || spans_sent < RAND_SPANS)
        begin
            case (phase % 8)
                0: k = ssk_pkg::K_W'(1);
                1: k = ssk_pkg::K_W'(64);
                2: k = ssk_pkg::K_W'($urandom_range(1, 64));
                3: k = ssk_pkg::K_W'(2);
                4: k = ssk_pkg::K_W'($urandom_range(1, 8));
                5: k = ssk_pkg::K_W'(0);
                6: k = ssk_pkg::K_W'($urandom_range(65, 127));
                default: k = ssk_pkg::K_W'($urandom_range(9, 63));
            endcase
            set_k(k);
            calm = ($urandom_range(3) == 0);
            repeat ($urandom_range(2, 3))
            begin
                hi  = (int'(k) >= 1 && int'(k) <= ssk_pkg::MAX_K_DEF) ? 2 * int'(k) + 8 : 20;
                len = ($urandom_range(9) == 0) ? $urandom_range(1, 200)
                                               : $urandom_range(1, hi);
                send_seq(len, $urandom_range(0, 100));
                rand_words += len;
                spans_sent++;
            end
            phase++;
        end
        calm = 1'b0;

        drain();
        if (tracker.errors == 0)
            $display("shortest_span_k_ones_top regression: pass");
        else
            $display("shortest_span_k_ones_top regression: fail");
        $finish;
    end

endmodule

[shortest_span_k_ones_top.f]
hdl/ssk_pkg.sv
hdl/ssk_ring.sv
hdl/ssk_front.sv
hdl/ssk_best.sv
hdl/shortest_span_k_ones_top.sv
verif/shortest_span_k_ones_top_test.sv
